// ===== rtl/sira_pkg.sv =====
// Shared constants, payload types and command codes of the sync id reservation allocator.
// Depends on nothing; every rtl file but sira_ram refers to it by scoped names.
package sira_pkg;

  localparam int NUM_PLAYERS    = 16;
  localparam int PLAYER_W       = 4;
  localparam int AREA_W         = 4;
  localparam int AREA_REF_W     = AREA_W + 1;     // top bit set means no area
  localparam int SLOTS_PER_AREA = 127;
  localparam int SLOT_W         = 7;
  localparam int SCNT_W         = SLOT_W + 1;
  localparam int QUOTA          = 8;
  localparam int QIDX_W         = 3;
  localparam int NCNT_W         = QIDX_W + 1;
  localparam int OWN_W          = 5;
  localparam int KEY_W          = 64;
  localparam int ID_W           = 16;
  localparam int CNT_W          = 5;
  localparam int RAM_AW         = AREA_W + SLOT_W;
  localparam int RAM_DEPTH      = NUM_PLAYERS * (1 << SLOT_W);

  localparam logic [OWN_W-1:0]      OWN_FREE = 5'h1F;
  localparam logic [OWN_W-1:0]      OWN_USED = 5'h1E;
  localparam logic [AREA_REF_W-1:0] NO_AREA  = 5'h10;
  localparam logic [ID_W-1:0]       ID_BASE_RESET = 16'd127;

  localparam logic [1:0] OP_CHANGE  = 2'd0;
  localparam logic [1:0] OP_USE     = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;   // no such operation, dropped

  localparam logic [1:0] K_CHANGE = 2'd0;
  localparam logic [1:0] K_DISC   = 2'd1;
  localparam logic [1:0] K_USE    = 2'd2;
  localparam logic [1:0] K_REL    = 2'd3;

  localparam int CQ_DEPTH = 2;
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = 3;
  localparam int RQ_CW    = 4;

  localparam int ADDR_W = 3;
  localparam logic REG_ID_BASE = 1'b0;

  typedef struct packed {
    logic [1:0]          operation;
    logic [PLAYER_W-1:0] player;
    logic                connected;
    logic signed [15:0]  course;
    logic signed [15:0]  act;
    logic signed [15:0]  level;
    logic signed [15:0]  area_index;
    logic [ID_W-1:0]     sync_id;
  } item_t;

  typedef struct packed {
    logic [PLAYER_W-1:0] recipient;
    logic [ID_W-1:0]     sync_id_res;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [PLAYER_W-1:0] player;
    logic [KEY_W-1:0]    key;
    logic [SLOT_W-1:0]   off;
  } cmd_t;

endpackage

// ===== rtl/sira_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module sira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sira_front.sv =====
// Front end: accepts input transactions, classifies them into commands and queues them.
// Depends on sira_pkg.
module sira_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sira_pkg::item_t     item,
  input  logic [15:0]         id_base,
  input  logic                cmd_pop,
  output logic                cmd_valid,
  output sira_pkg::cmd_t      cmd
);

  sira_pkg::cmd_t cq [sira_pkg::CQ_DEPTH];
  logic       wptr, rptr;
  logic [1:0] count;

  sira_pkg::cmd_t c_new;
  logic           keep;
  logic [16:0]    diff;
  logic           do_push, do_pop;

  always_comb begin
    diff = {1'b0, item.sync_id} - {1'b0, id_base};
    c_new.player = item.player;
    c_new.key    = {item.area_index, item.level, item.act, item.course};
    c_new.off    = diff[sira_pkg::SLOT_W-1:0];
    c_new.kind   = sira_pkg::K_CHANGE;
    keep         = 1'b0;
    case (item.operation)
      sira_pkg::OP_CHANGE: begin
        c_new.kind = item.connected ? sira_pkg::K_CHANGE : sira_pkg::K_DISC;
        keep       = 1'b1;
      end
      sira_pkg::OP_USE, sira_pkg::OP_RELEASE: begin
        c_new.kind = (item.operation == sira_pkg::OP_USE) ? sira_pkg::K_USE : sira_pkg::K_REL;
        // drop ids below the base or past the last slot
        keep = !diff[16] && (diff[15:0] < 16'(sira_pkg::SLOTS_PER_AREA));
      end
      default: keep = 1'b0;
    endcase
  end

  assign full      = (count == 2'(sira_pkg::CQ_DEPTH));
  assign cmd_valid = (count != 2'd0);
  assign cmd       = cq[rptr];
  assign do_push   = push && !full && keep;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      cq[wptr] <= c_new;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/sira_back.sv =====
// Back end: area table, slot owner sweeps, quota top-up and the result queue.
// Depends on sira_pkg and sira_ram.
module sira_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  sira_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic [15:0]         id_base,
  output sira_pkg::result_t   result,
  output logic                empty,
  input  logic                pop
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MARK     = 4'd1;
  localparam logic [3:0] S_DROP     = 4'd2;
  localparam logic [3:0] S_DROP_END = 4'd3;
  localparam logic [3:0] S_SEARCH   = 4'd4;
  localparam logic [3:0] S_CLEAR    = 4'd5;
  localparam logic [3:0] S_TOP1     = 4'd6;
  localparam logic [3:0] S_TOP2     = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;

  localparam logic [sira_pkg::SCNT_W-1:0] SLOTS = sira_pkg::SCNT_W'(sira_pkg::SLOTS_PER_AREA);
  localparam logic [sira_pkg::NCNT_W-1:0] QMAX  = sira_pkg::NCNT_W'(sira_pkg::QUOTA);

  logic [3:0] state;

  logic                              area_valid   [sira_pkg::NUM_PLAYERS];
  logic [sira_pkg::KEY_W-1:0]        area_key     [sira_pkg::NUM_PLAYERS];
  logic [sira_pkg::CNT_W-1:0]        area_players [sira_pkg::NUM_PLAYERS];
  logic [sira_pkg::AREA_REF_W-1:0]   player_area  [sira_pkg::NUM_PLAYERS];

  sira_pkg::cmd_t                    c;
  logic [sira_pkg::AREA_W-1:0]       cur_area;
  logic [sira_pkg::SCNT_W-1:0]       scnt;
  logic                              pv;
  logic [sira_pkg::SLOT_W-1:0]       pidx;
  logic [sira_pkg::SLOT_W-1:0]       list [sira_pkg::QUOTA];
  logic [sira_pkg::NCNT_W-1:0]       n;
  logic [sira_pkg::NCNT_W-1:0]       k;
  logic                              taken;

  logic                              ram_we;
  logic [sira_pkg::RAM_AW-1:0]       ram_waddr, ram_raddr;
  logic [sira_pkg::OWN_W-1:0]        ram_wdata, ram_rdata;

  sira_pkg::result_t                 rq [sira_pkg::RQ_DEPTH];
  logic [sira_pkg::RQ_AW-1:0]        rq_w, rq_r;
  logic [sira_pkg::RQ_CW-1:0]        rq_count;
  logic                              rq_full, rq_push, rq_pop;
  sira_pkg::result_t                 rq_new;

  logic [sira_pkg::AREA_REF_W-1:0]   a_in;
  logic                              issue, scan_done, own_hit, free_hit, room;
  logic                              hit, free_found;
  logic [sira_pkg::AREA_W-1:0]       hit_idx, free_idx;
  logic [sira_pkg::OWN_W-1:0]        me;

  sira_ram #(.WIDTH(sira_pkg::OWN_W), .DEPTH(sira_pkg::RAM_DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign a_in      = player_area[cmd.player];
  assign me        = {1'b0, c.player};
  assign issue     = (scnt < SLOTS);
  assign scan_done = !issue && !pv;
  assign room      = (n < QMAX);
  assign own_hit   = pv && (ram_rdata == me);
  assign free_hit  = pv && (ram_rdata == sira_pkg::OWN_FREE);
  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign ram_raddr = {cur_area, scnt[sira_pkg::SLOT_W-1:0]};

  // first matching area, else first unused entry
  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = sira_pkg::NUM_PLAYERS - 1; i >= 0; i--) begin
      if (area_valid[i] && area_key[i] == c.key) begin
        hit     = 1'b1;
        hit_idx = sira_pkg::AREA_W'(i);
      end
      if (!area_valid[i]) begin
        free_found = 1'b1;
        free_idx   = sira_pkg::AREA_W'(i);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {cur_area, pidx};
    ram_wdata = sira_pkg::OWN_FREE;
    case (state)
      S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = {cur_area, c.off};
        ram_wdata = (c.kind == sira_pkg::K_USE) ? sira_pkg::OWN_USED : sira_pkg::OWN_FREE;
      end
      S_DROP: ram_we = own_hit;
      S_CLEAR: begin
        ram_we    = issue;
        ram_waddr = {cur_area, scnt[sira_pkg::SLOT_W-1:0]};
      end
      S_TOP2: begin
        ram_we    = free_hit && room;
        ram_wdata = me;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign rq_full = (rq_count == sira_pkg::RQ_CW'(sira_pkg::RQ_DEPTH));
  assign rq_push = (state == S_EMIT) && !rq_full;
  assign empty   = (rq_count == '0);
  assign rq_pop  = pop && !empty;
  assign result  = rq[rq_r];

  always_comb begin
    rq_new.recipient   = c.player;
    rq_new.sync_id_res = id_base + {9'b0, list[k[sira_pkg::QIDX_W-1:0]]};
    rq_new.last        = (k + 1'b1 == n);
  end

  always_ff @(posedge clk) begin
    if (rq_push) rq[rq_w] <= rq_new;
    if (rst) begin
      rq_w     <= '0;
      rq_r     <= '0;
      rq_count <= '0;
    end else begin
      if (rq_push) rq_w <= rq_w + 1'b1;
      if (rq_pop)  rq_r <= rq_r + 1'b1;
      rq_count <= rq_count + sira_pkg::RQ_CW'(rq_push) - sira_pkg::RQ_CW'(rq_pop);
    end
  end

  // payload of the sweep pipeline
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      c        <= cmd;
      cur_area <= a_in[sira_pkg::AREA_W-1:0];
    end
    if (state == S_SEARCH) begin
      cur_area <= hit ? hit_idx : free_idx;
    end
    pidx <= scnt[sira_pkg::SLOT_W-1:0];
    if ((state == S_TOP1 && own_hit && room) || (state == S_TOP2 && free_hit && room)) begin
      list[n[sira_pkg::QIDX_W-1:0]] <= pidx;
    end
    if (state == S_SEARCH && !hit && free_found) begin
      area_key[free_idx] <= c.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scnt  <= '0;
      pv    <= 1'b0;
      n     <= '0;
      k     <= '0;
      taken <= 1'b0;
      for (int i = 0; i < sira_pkg::NUM_PLAYERS; i++) begin
        area_valid[i]   <= 1'b0;
        area_players[i] <= '0;
        player_area[i]  <= sira_pkg::NO_AREA;
      end
    end else begin
      if (state == S_DROP || state == S_TOP1 || state == S_TOP2) begin
        pv <= issue;
        if (issue) scnt <= scnt + 1'b1;
      end else begin
        pv <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          scnt <= '0;
          if (cmd_valid) begin
            case (cmd.kind)
              sira_pkg::K_DISC: begin
                if (!a_in[sira_pkg::AREA_W]) state <= S_DROP;
              end
              sira_pkg::K_CHANGE: begin
                if (a_in[sira_pkg::AREA_W]) begin
                  state <= S_SEARCH;
                end else if (area_key[a_in[sira_pkg::AREA_W-1:0]] != cmd.key) begin
                  state <= S_DROP;
                end
              end
              default: begin
                if (!a_in[sira_pkg::AREA_W]) state <= S_MARK;
              end
            endcase
          end
        end
        S_MARK: begin
          scnt  <= '0;
          n     <= '0;
          taken <= 1'b0;
          state <= S_TOP1;
        end
        S_DROP: begin
          if (scan_done) state <= S_DROP_END;
        end
        S_DROP_END: begin
          if (area_players[cur_area] != '0) begin
            area_players[cur_area] <= area_players[cur_area] - 1'b1;
          end
          if (area_players[cur_area] <= sira_pkg::CNT_W'(1)) begin
            area_valid[cur_area] <= 1'b0;
          end
          player_area[c.player] <= sira_pkg::NO_AREA;
          state <= (c.kind == sira_pkg::K_DISC) ? S_IDLE : S_SEARCH;
        end
        S_SEARCH: begin
          scnt  <= '0;
          n     <= '0;
          taken <= 1'b0;
          if (hit) begin
            area_players[hit_idx] <= area_players[hit_idx] + 1'b1;
            player_area[c.player] <= {1'b0, hit_idx};
            state <= S_TOP1;
          end else if (free_found) begin
            area_valid[free_idx]   <= 1'b1;
            area_players[free_idx] <= sira_pkg::CNT_W'(1);
            player_area[c.player]  <= {1'b0, free_idx};
            state <= S_CLEAR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          if (issue) begin
            scnt <= scnt + 1'b1;
          end else begin
            scnt  <= '0;
            state <= S_TOP1;
          end
        end
        S_TOP1: begin
          if (own_hit && room) n <= n + 1'b1;
          if (scan_done) begin
            scnt  <= '0;
            state <= S_TOP2;
          end
        end
        S_TOP2: begin
          if (free_hit && room) begin
            n     <= n + 1'b1;
            taken <= 1'b1;
          end
          if (scan_done) begin
            k     <= '0;
            state <= taken ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (rq_push) begin
            k <= k + 1'b1;
            if (k + 1'b1 == n) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_count <= sira_pkg::RQ_CW'(sira_pkg::RQ_DEPTH))
    else $error("result queue overflow");

  a_pv_scan: assert property (@(posedge clk) disable iff (rst)
    pv |-> (state == S_DROP || state == S_TOP1 || state == S_TOP2))
    else $error("sweep data outside a sweep");

  a_emit_k: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (k < n && n <= QMAX))
    else $error("emit index out of list");

  a_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state != S_IDLE) || $past(cmd.kind) == sira_pkg::K_DISC
      || $past(cmd.kind) == sira_pkg::K_CHANGE || $past(cmd.kind) == sira_pkg::K_USE
      || $past(cmd.kind) == sira_pkg::K_REL)
    else $error("command lost");

endmodule

// ===== rtl/sync_id_reservation_allocator.sv =====
// Top level of the sync id reservation allocator: config register, front end, back end.
// Depends on sira_pkg, sira_front, sira_back (and through it sira_ram).
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------
//  input    | push / full        | item   (sira_pkg::item_t)
//  results  | pop / empty        | result (sira_pkg::result_t)
//  config   | psel/penable/pwrite| paddr, pwdata, prdata
//
// Sequence: an ignored transaction is dropped in the front end. In the back end a use or
// release marks its slot, then makes two sweeps of the 127-slot owner RAM through its
// single read port, then emits the listed ids one per cycle while the result queue has
// room; a change takes up to one more sweep to free the old area and one to clear a new one.
// Reset: synchronous, clears the area table, player map and both queues; the owner
// RAM needs no clearing since an area is swept clean when it is created.
// Stalls: a full result queue holds the back end in its emit step; a full command
// queue raises full while results may still wait to be popped.
module sync_id_reservation_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  sira_pkg::item_t                   item,
  output logic                              empty,
  input  logic                              pop,
  output sira_pkg::result_t                 result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sira_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [15:0]    id_base;
  logic           cmd_valid, cmd_pop;
  sira_pkg::cmd_t cmd;

  assign pready = 1'b1;

  // byte lanes are ignored: the register index is the word address
  always_ff @(posedge clk) begin
    if (rst) begin
      id_base <= sira_pkg::ID_BASE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == sira_pkg::REG_ID_BASE) begin
      id_base <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == sira_pkg::REG_ID_BASE) ? {16'b0, id_base} : 32'b0;

  sira_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .id_base   (id_base),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  sira_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .id_base   (id_base),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== sim/sync_id_reservation_allocator_tb.sv =====
// Self-checking testbench for sync_id_reservation_allocator: directed table, then random traffic.
// Depends on rtl/sira_pkg.sv and the allocator RTL; predicts every reserved id list itself.
`timescale 1ns / 1ps

module sync_id_reservation_allocator_tb;

  localparam int SETTLE     = 2000;   // three queued commands at the worst back-end latency
  localparam int WDOG_LIMIT = 20000;  // cycles without any accepted transaction
  localparam int HOLD_LONG  = 3000;   // long receiver hold-off
  localparam int N_RANDOM   = 80;     // random items per phase
  localparam int NONE       = sira_pkg::NUM_PLAYERS;
  localparam int AW         = sira_pkg::ADDR_W;
  localparam int PW         = sira_pkg::PLAYER_W;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  sira_pkg::item_t   item = '0;
  logic              empty;
  logic              pop = 1'b0;
  sira_pkg::result_t result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AW-1:0]     paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  sync_id_reservation_allocator i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Mirror of the allocator state: slot owners hold a player index or a marker.
  localparam logic [15:0] SL_FREE = 16'hFFFF;
  localparam logic [15:0] SL_USED = 16'hFFFE;

  logic [15:0] slot_own [sira_pkg::NUM_PLAYERS][sira_pkg::SLOTS_PER_AREA];
  logic [63:0] area_loc [sira_pkg::NUM_PLAYERS];
  bit          area_live [sira_pkg::NUM_PLAYERS];
  int          area_count [sira_pkg::NUM_PLAYERS];
  int          player_at [sira_pkg::NUM_PLAYERS];
  logic [15:0] base_id;

  sira_pkg::result_t id_lists [$];     // reserved ids still to come out of the block
  int      errors = 0;
  int      items_sent = 0;
  int      ids_seen = 0;
  int      lists_seen = 0;
  bit      hold_req = 1'b0;
  bit      accepted_any;

  // Free every slot the player owns; drop the area once nobody is left in it.
  task automatic leave_area(int p);
    int a;
    a = player_at[p];
    if (a >= sira_pkg::NUM_PLAYERS) begin
      player_at[p] = NONE;
      return;
    end
    for (int i = 0; i < sira_pkg::SLOTS_PER_AREA; i++)
      if (slot_own[a][i] == 16'(p)) slot_own[a][i] = SL_FREE;
    if (area_count[a] > 0) area_count[a]--;
    if (area_count[a] == 0) area_live[a] = 1'b0;
    player_at[p] = NONE;
  endtask

  // Top the player up to QUOTA slots and queue the id list if anything was taken.
  task automatic top_up_ids(int p);
    int  a;
    int  lst[$];
    bit  took;
    sira_pkg::result_t r;
    a = player_at[p];
    took = 1'b0;
    if (a >= sira_pkg::NUM_PLAYERS) return;
    for (int i = 0; i < sira_pkg::SLOTS_PER_AREA && lst.size() < sira_pkg::QUOTA; i++)
      if (slot_own[a][i] == 16'(p)) lst.push_back(i);
    for (int i = 0; i < sira_pkg::SLOTS_PER_AREA && lst.size() < sira_pkg::QUOTA; i++)
      if (slot_own[a][i] == SL_FREE) begin
        slot_own[a][i] = 16'(p);
        lst.push_back(i);
        took = 1'b1;
      end
    if (!took) return;
    foreach (lst[k]) begin
      r.recipient   = PW'(p);
      r.sync_id_res = base_id + 16'(lst[k]);
      r.last        = (k == lst.size() - 1);
      id_lists.push_back(r);
    end
  endtask

  task automatic predict_ids(sira_pkg::item_t it);
    int p;
    int a;
    logic [63:0] loc;
    logic [16:0] off;
    p   = it.player;
    loc = {it.area_index, it.level, it.act, it.course};
    a   = player_at[p];
    case (it.operation)
      sira_pkg::OP_CHANGE: begin
        if (!it.connected) begin
          leave_area(p);
          return;
        end
        if (a < sira_pkg::NUM_PLAYERS && area_loc[a] == loc) return;
        leave_area(p);
        for (int i = 0; i < sira_pkg::NUM_PLAYERS; i++)
          if (area_live[i] && area_loc[i] == loc) begin
            area_count[i]++;
            player_at[p] = i;
            top_up_ids(p);
            return;
          end
        for (int i = 0; i < sira_pkg::NUM_PLAYERS; i++)
          if (!area_live[i]) begin
            area_live[i]  = 1'b1;
            area_loc[i]   = loc;
            area_count[i] = 1;
            for (int s = 0; s < sira_pkg::SLOTS_PER_AREA; s++) slot_own[i][s] = SL_FREE;
            player_at[p] = i;
            top_up_ids(p);
            return;
          end
      end
      sira_pkg::OP_USE, sira_pkg::OP_RELEASE: begin
        if (a >= sira_pkg::NUM_PLAYERS) return;
        if (it.sync_id < base_id) return;
        off = 17'(it.sync_id) - 17'(base_id);
        if (off >= sira_pkg::SLOTS_PER_AREA) return;
        slot_own[a][off] = (it.operation == sira_pkg::OP_USE) ? SL_USED : SL_FREE;
        top_up_ids(p);
      end
      default: ;  // unknown operation: ignored
    endcase
  endtask

  // Offer one transaction; keep push high if the next one follows at once.
  task automatic send_item(sira_pkg::item_t it);
    int gap;
    item <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    gap = ($urandom_range(0, 9) < 5) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 200);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected id has come out, then let the back end go quiet.
  task automatic drain();
    while (id_lists.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_base(logic [15:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AW'(4 * sira_pkg::REG_ID_BASE);
    pwdata  <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    base_id = v;
    // read it back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== v) begin
      $error("id_base readback: expected %0d, got %0d", v, prdata[15:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sira_pkg::item_t mk(logic [1:0] op, int p, bit con, logic [63:0] loc,
                                         logic [15:0] sid);
    sira_pkg::item_t it;
    it.operation  = op;
    it.player     = PW'(p);
    it.connected  = con;
    it.course     = loc[15:0];
    it.act        = loc[31:16];
    it.level      = loc[47:32];
    it.area_index = loc[63:48];
    it.sync_id    = sid;
    return it;
  endfunction

  // Receiver: check each popped id against the oldest expectation, with random stalls.
  initial begin
    int stall;
    sira_pkg::result_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        ids_seen++;
        if (id_lists.size() == 0) begin
          $error("unexpected id %0d for player %0d", result.sync_id_res, result.recipient);
          errors++;
        end else begin
          want = id_lists.pop_front();
          if (result.recipient !== want.recipient) begin
            $error("recipient: expected %0d, got %0d", want.recipient, result.recipient);
            errors++;
          end
          if (result.sync_id_res !== want.sync_id_res) begin
            $error("sync_id_res: expected %0d, got %0d", want.sync_id_res, result.sync_id_res);
            errors++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result.last);
            errors++;
          end
          if (want.last) lists_seen++;
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_LONG;
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 150);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      accepted_any = (push && !full) || (pop && !empty);
      quiet = accepted_any ? 0 : quiet + 1;
      if (quiet >= WDOG_LIMIT) begin
        $display("sync_id_reservation_allocator_tb failed");
        $finish;
      end
    end
  end

  typedef struct {
    sira_pkg::item_t it;
    int              n_ids;     // -1: take the predictor's list
    logic [15:0]     first_id;
  } row_t;

  row_t dir_rows [$];
  logic [63:0] loc_pool [4];

  initial begin
    row_t  rw;
    sira_pkg::item_t   it;
    sira_pkg::result_t exp_r;
    int    mark;
    int    roll;
    logic [15:0] bases [5];

    for (int p = 0; p < sira_pkg::NUM_PLAYERS; p++) player_at[p] = NONE;
    for (int a = 0; a < sira_pkg::NUM_PLAYERS; a++) begin
      area_live[a]  = 1'b0;
      area_count[a] = 0;
      area_loc[a]   = '0;
    end
    base_id = sira_pkg::ID_BASE_RESET;

    loc_pool[0] = 64'h0;
    loc_pool[1] = {16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000};
    loc_pool[2] = {16'h0001, 16'h0002, 16'h0003, 16'h0004};
    loc_pool[3] = {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

    // Directed table; typed counts only where the answer is obvious.
    dir_rows = '{
      '{mk(sira_pkg::OP_CHANGE, 0, 1, loc_pool[0], 16'h0), 8, 16'd127},     // first area
      '{mk(sira_pkg::OP_CHANGE, 0, 1, loc_pool[0], 16'h0), 0, 16'd0},       // same location
      '{mk(sira_pkg::OP_NONE, 0, 1, loc_pool[2], 16'd130), 0, 16'd0},       // unknown op
      '{mk(sira_pkg::OP_USE, 0, 0, 64'h0, 16'd127), -1, 16'd0},             // owned slot used
      '{mk(sira_pkg::OP_RELEASE, 0, 0, 64'h0, 16'd126), 0, 16'd0},          // below base
      '{mk(sira_pkg::OP_RELEASE, 0, 0, 64'h0, 16'd254), 0, 16'd0},          // past last slot
      '{mk(sira_pkg::OP_RELEASE, 0, 0, 64'h0, 16'd253), -1, 16'd0},         // last slot
      '{mk(sira_pkg::OP_USE, 1, 0, 64'h0, 16'd127), 0, 16'd0},              // no area yet
      '{mk(sira_pkg::OP_CHANGE, 1, 1, loc_pool[1], 16'hFFFF), 8, 16'd127},  // second area
      '{mk(sira_pkg::OP_CHANGE, 2, 1, loc_pool[0], 16'h0), -1, 16'd0},      // join first area
      '{mk(sira_pkg::OP_RELEASE, 2, 0, 64'h0, 16'd127), -1, 16'd0},         // free a slot
      '{mk(sira_pkg::OP_CHANGE, 0, 0, loc_pool[0], 16'h0), 0, 16'd0},       // disconnect
      '{mk(sira_pkg::OP_CHANGE, 0, 0, loc_pool[3], 16'h0), 0, 16'd0},       // disconnect again
      '{mk(sira_pkg::OP_CHANGE, 2, 1, loc_pool[3], 16'hFFFF), -1, 16'd0},   // move, drop area
      '{mk(sira_pkg::OP_USE, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF), 0, 16'd0},
      '{mk(sira_pkg::OP_USE, 15, 1, loc_pool[1], 16'd200), 0, 16'd0},
      '{mk(sira_pkg::OP_CHANGE, 15, 1, loc_pool[1], 16'h0), -1, 16'd0},
      '{mk(sira_pkg::OP_RELEASE, 1, 1, loc_pool[1], 16'd127), -1, 16'd0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      mark = id_lists.size();
      predict_ids(rw.it);
      if (rw.n_ids >= 0) begin
        while (id_lists.size() > mark) void'(id_lists.pop_back());
        for (int k = 0; k < rw.n_ids; k++) begin
          exp_r.recipient   = rw.it.player;
          exp_r.sync_id_res = rw.first_id + 16'(k);
          exp_r.last        = (k == rw.n_ids - 1);
          id_lists.push_back(exp_r);
        end
      end
      send_item(rw.it);
    end
    stop_sending();

    // Random phases, each under its own id_base; the extremes come first.
    bases = '{16'd0, 16'hFFFF, 16'd65500, 16'($urandom), sira_pkg::ID_BASE_RESET};
    foreach (bases[ph]) begin
      drain();
      write_base(bases[ph]);
      // phase 3 mints a fresh location for one entry of the pool
      if (ph == 3) loc_pool[2] = {$urandom, $urandom};
      for (int n = 0; n < N_RANDOM; n++) begin
        if (ph == 1 && n == 10) hold_req = 1'b1;  // receiver stalls while items keep coming
        if (ph == 2 && n == 40) begin
          stop_sending();
          while (id_lists.size() != 0) @(posedge clk);
        end
        roll = $urandom_range(0, 99);
        it.operation  = (roll < 35) ? sira_pkg::OP_CHANGE : (roll < 65) ? sira_pkg::OP_USE :
                        (roll < 95) ? sira_pkg::OP_RELEASE : sira_pkg::OP_NONE;
        it.player     = PW'($urandom);
        it.connected  = ($urandom_range(0, 9) != 0);
        {it.area_index, it.level, it.act, it.course} =
          ($urandom_range(0, 9) < 9) ? loc_pool[$urandom_range(0, 3)] : {$urandom, $urandom};
        it.sync_id    = ($urandom_range(0, 9) < 9) ? base_id + 16'($urandom_range(0, 127))
                                                   : 16'($urandom);
        predict_ids(it);
        send_item(it);
      end
      stop_sending();
    end

    drain();
    if (id_lists.size() != 0) errors++;

    $display("ran %0d transactions over 5 id_base settings; %0d ids in %0d lists checked",
             items_sent, ids_seen, lists_seen);
    if (errors == 0) begin
      $display("sync_id_reservation_allocator_tb passed");
    end else begin
      $display("sync_id_reservation_allocator_tb failed");
    end
    $finish;
  end

endmodule
